// File: sv/lcwc_pkg.sv
// Shared types, codes and constants of the load cell weight conditioner.
package lcwc_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 2;
    localparam int RAW_W     = 24;
    localparam int DIFF_W    = RAW_W + 1;
    localparam int MASS_W    = 16;
    localparam int MASS_CG_W = 23;
    localparam int PROD_W    = 48;
    localparam int W_W       = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Request kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TARE   = 2'd1;
    localparam logic [1:0] KIND_ZERO   = 2'd2;
    localparam logic [1:0] KIND_REF    = 2'd3;

    // Result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ABSENT   = 2'd1;
    localparam logic [1:0] STAT_SPAN_LOW = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_MASS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DEADBAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_DEADBAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN      = 3'd4;

    // Per-channel calibration record
    typedef struct packed {
        logic [RAW_W-1:0]  tare;
        logic [RAW_W-1:0]  zref;
        logic [DIFF_W-1:0] span;
        logic [W_W-1:0]    shown;
    } chan_rec_t;

    localparam chan_rec_t REC_RESET = '{
        tare:  '0,
        zref:  '0,
        span:  DIFF_W'(100),
        shown: '0
    };

endpackage

// File: sv/lcwc_ifs.sv
// Handshake channel interfaces: reading requests, results and register writes.
interface lcwc_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [lcwc_pkg::CH_W-1:0]         channel;
    logic signed [lcwc_pkg::RAW_W-1:0] raw_reading;

    modport source (output valid, kind, channel, raw_reading, input ready);
    modport sink   (input valid, kind, channel, raw_reading, output ready);
endinterface

interface lcwc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lcwc_pkg::CH_W-1:0]       out_channel;
    logic [1:0]                      status;
    logic signed [lcwc_pkg::W_W-1:0] weight_cg;
    logic signed [lcwc_pkg::W_W-1:0] shown_cg;

    modport source (output valid, out_channel, status, weight_cg, shown_cg, input ready);
    modport sink   (input valid, out_channel, status, weight_cg, shown_cg, output ready);
endinterface

interface lcwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lcwc_pkg::CFG_IDX_W-1:0] index;
    logic [lcwc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/lcwc_chan_mem.sv
// Per-channel calibration record memory with registered read and reset-valid bits.
module lcwc_chan_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [lcwc_pkg::CH_W-1:0] rd_addr,
    output lcwc_pkg::chan_rec_t       rd_data,
    input  logic                      wr_en,
    input  logic [lcwc_pkg::CH_W-1:0] wr_addr,
    input  lcwc_pkg::chan_rec_t       wr_data
);

    lcwc_pkg::chan_rec_t               mem [lcwc_pkg::CHANNELS];
    lcwc_pkg::chan_rec_t               rd_data_reg;
    logic                              rd_valid_reg;
    logic [lcwc_pkg::CHANNELS-1:0]     valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as its reset record
    assign rd_data = rd_valid_reg ? rd_data_reg : lcwc_pkg::REC_RESET;

endmodule

// File: sv/lcwc_div.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module lcwc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lcwc_pkg::PROD_W-1:0]   dividend,
    input  logic [lcwc_pkg::DIFF_W-1:0]   divisor,
    output logic                          done,
    output logic [lcwc_pkg::PROD_W-1:0]   quotient
);

    logic [lcwc_pkg::PROD_W-1:0]    dvd_reg;
    logic [lcwc_pkg::DIFF_W-1:0]    dsr_reg;
    logic [lcwc_pkg::DIFF_W-1:0]    rem_reg;
    logic [lcwc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           done_reg;
    logic [lcwc_pkg::DIFF_W:0]      shifted;
    logic [lcwc_pkg::DIFF_W:0]      trial;
    logic                           q_bit;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[lcwc_pkg::PROD_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        q_bit   = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // Quotient bits shift in as the dividend bits shift out
            dvd_reg <= {dvd_reg[lcwc_pkg::PROD_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[lcwc_pkg::DIFF_W-1:0] : shifted[lcwc_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == lcwc_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                cnt_reg <= lcwc_pkg::DIV_CNT_W'(lcwc_pkg::DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - lcwc_pkg::DIV_CNT_W'(1);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: sv/load_cell_weight_conditioner_unit.sv
// Top level of the load cell weight conditioner: sequencer, arithmetic and result register.
//
// Channels: "reading" takes one request (kind, channel, signed raw reading);
// "result" returns exactly one result per request (channel, status, weight
// and shown weight in centigrams); "cfg" writes a register by index and is
// always ready. Register writes are expected only while no request is in work.
//
// Sequence: a sample runs load, multiply, divider start, divide until the 48-step
// bit-serial divider is done, saturate and finish (a zero span goes from multiply to
// finish); a reference capture runs load, multiply and finish; tare and zero captures
// and requests for absent channels run load and finish. A request is accepted only in
// idle, which the sequencer reenters as the result is registered. Each request reads
// its record from a registered-read memory and, unless absent or span-low, writes it back.
//
// Reset: registers return to their defaults (all channels present, 100 g
// mass, deadbands 5 and 3 cg, min span 10) and every channel record reads as
// tare 0, zero 0, span 100, shown 0 until it is first written.
//
// Stall: a finished result waits in the output register; the next request is
// accepted meanwhile and runs up to its own result, which holds until the
// receiver takes the earlier one.
module load_cell_weight_conditioner_unit (
    input  logic       clk,
    input  logic       rst_n,
    lcwc_req_if.sink   reading,
    lcwc_rsp_if.source result,
    lcwc_cfg_if.sink   cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DVS  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SAT  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam int RAW_W  = lcwc_pkg::RAW_W;
    localparam int DIFF_W = lcwc_pkg::DIFF_W;
    localparam int PROD_W = lcwc_pkg::PROD_W;
    localparam int W_W    = lcwc_pkg::W_W;
    localparam int MCG_W  = lcwc_pkg::MASS_CG_W;

    // Configuration registers
    logic [lcwc_pkg::CHANNELS-1:0]  present_mask_reg;
    logic [MCG_W-1:0]               mass_cg_reg;
    logic [15:0]                    zero_db_reg;
    logic [15:0]                    disp_db_reg;
    logic [15:0]                    min_span_reg;
    logic [MCG_W-1:0]               mass_cg_new;

    // Sequencer and datapath registers
    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [lcwc_pkg::CH_W-1:0]      ch_reg, ch_next;
    logic [RAW_W-1:0]               raw_reg, raw_next;
    logic                           present_reg, present_next;
    lcwc_pkg::chan_rec_t            rec_reg, rec_next;
    logic [DIFF_W-1:0]              diff_reg, diff_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic                           neg_reg, neg_next;
    logic                           small_reg, small_next;
    logic [W_W-1:0]                 w_reg, w_next;

    // Result register
    logic                           out_valid_reg, out_valid_next;
    logic [lcwc_pkg::CH_W-1:0]      out_ch_reg, out_ch_next;
    logic [1:0]                     out_status_reg, out_status_next;
    logic [W_W-1:0]                 out_weight_reg, out_weight_next;
    logic [W_W-1:0]                 out_shown_reg, out_shown_next;

    // Memory and divider connections
    logic                           mem_rd_en;
    lcwc_pkg::chan_rec_t            mem_rd_data;
    logic                           mem_wr_en;
    lcwc_pkg::chan_rec_t            mem_wr_data;
    logic                           div_start;
    logic                           div_done;
    logic [PROD_W-1:0]              div_quot;
    logic [PROD_W-1:0]              prod_mag;
    logic [DIFF_W-1:0]              span_mag;

    // Combinational helpers
    logic                           req_fire;
    logic                           fin_fire;
    logic [RAW_W-1:0]               base_sel;
    logic [DIFF_W-1:0]              diff_mag;
    logic [W_W-1:0]                 q_sat;
    logic [W_W-1:0]                 w_mag;
    logic [W_W:0]                   shown_diff;
    logic [W_W:0]                   shown_diff_mag;
    logic [W_W-1:0]                 shown_new;

    assign req_fire = reading.valid && reading.ready;
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    // Mass in centigrams: data * 100 as shifts
    assign mass_cg_new = MCG_W'({cfg.data, 6'b0}) + MCG_W'({cfg.data, 5'b0})
                       + MCG_W'({cfg.data, 2'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg <= '1;
            mass_cg_reg      <= MCG_W'(10000);
            zero_db_reg      <= 16'd5;
            disp_db_reg      <= 16'd3;
            min_span_reg     <= 16'd10;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lcwc_pkg::REG_PRESENT_MASK:  present_mask_reg <= cfg.data[lcwc_pkg::CHANNELS-1:0];
                lcwc_pkg::REG_CALIB_MASS:    mass_cg_reg      <= mass_cg_new;
                lcwc_pkg::REG_ZERO_DEADBAND: zero_db_reg      <= cfg.data;
                lcwc_pkg::REG_DISP_DEADBAND: disp_db_reg      <= cfg.data;
                lcwc_pkg::REG_MIN_SPAN:      min_span_reg     <= cfg.data;
                default:                     ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    lcwc_chan_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (reading.channel),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ch_reg),
        .wr_data (mem_wr_data)
    );

    assign mem_rd_en = req_fire;
    assign div_start = (state_reg == S_DVS);
    assign prod_mag  = prod_reg[PROD_W-1] ? (~prod_reg + PROD_W'(1)) : prod_reg;
    assign span_mag  = rec_reg.span[DIFF_W-1] ? (~rec_reg.span + DIFF_W'(1)) : rec_reg.span;

    lcwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (span_mag),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        // Reference capture measures against the zero, everything else against the tare
        base_sel = (kind_reg == lcwc_pkg::KIND_REF) ? mem_rd_data.zref : mem_rd_data.tare;
        diff_mag = diff_reg[DIFF_W-1] ? (~diff_reg + DIFF_W'(1)) : diff_reg;

        // Saturate the signed quotient to 32 bits
        if (div_quot[PROD_W-1:W_W-1] != '0)
        begin
            q_sat = neg_reg ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end
        else
        begin
            q_sat = neg_reg ? (~div_quot[W_W-1:0] + W_W'(1)) : div_quot[W_W-1:0];
        end
        w_mag = q_sat[W_W-1] ? (~q_sat + W_W'(1)) : q_sat;

        // Display hysteresis against the stored shown weight
        shown_diff     = {w_reg[W_W-1], w_reg} - {rec_reg.shown[W_W-1], rec_reg.shown};
        shown_diff_mag = shown_diff[W_W] ? (~shown_diff + (W_W+1)'(1)) : shown_diff;
        shown_new      = (shown_diff_mag >= (W_W+1)'(disp_db_reg)) ? w_reg : rec_reg.shown;
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        ch_next         = ch_reg;
        raw_next        = raw_reg;
        present_next    = present_reg;
        rec_next        = rec_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        small_next      = small_reg;
        w_next          = w_reg;
        out_valid_next  = out_valid_reg;
        out_ch_next     = out_ch_reg;
        out_status_next = out_status_reg;
        out_weight_next = out_weight_reg;
        out_shown_next  = out_shown_reg;
        mem_wr_en       = 1'b0;
        mem_wr_data     = rec_reg;

        // Drop the result once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next  = reading.kind;
                    ch_next    = reading.channel;
                    raw_next   = reading.raw_reading;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rec_next     = mem_rd_data;
                present_next = present_mask_reg[ch_reg];
                diff_next    = DIFF_W'($signed({raw_reg[RAW_W-1], raw_reg})
                                       - $signed({base_sel[RAW_W-1], base_sel}));
                w_next       = '0;
                if (!present_mask_reg[ch_reg] || (kind_reg == lcwc_pkg::KIND_TARE)
                    || (kind_reg == lcwc_pkg::KIND_ZERO))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (kind_reg == lcwc_pkg::KIND_SAMPLE)
                begin
                    prod_next = PROD_W'($signed(diff_reg) * $signed({1'b0, mass_cg_reg}));
                    neg_next  = diff_reg[DIFF_W-1] ^ rec_reg.span[DIFF_W-1];
                    // Zero span skips the divider and reads as zero weight
                    state_next = (rec_reg.span == '0) ? S_FIN : S_DVS;
                end
                else
                begin
                    small_next = (diff_mag < DIFF_W'(min_span_reg));
                    state_next = S_FIN;
                end
            end
            S_DVS:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                // Force small weights to zero
                w_next     = (w_mag < W_W'(zero_db_reg)) ? '0 : q_sat;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_ch_next     = ch_reg;
                    out_status_next = lcwc_pkg::STAT_OK;
                    out_weight_next = '0;
                    out_shown_next  = '0;
                    state_next      = S_IDLE;
                    if (!present_reg)
                    begin
                        out_status_next = lcwc_pkg::STAT_ABSENT;
                    end
                    else
                    begin
                        case (kind_reg)
                            lcwc_pkg::KIND_SAMPLE:
                            begin
                                out_weight_next   = w_reg;
                                out_shown_next    = shown_new;
                                mem_wr_en         = 1'b1;
                                mem_wr_data.shown = shown_new;
                            end
                            lcwc_pkg::KIND_TARE:
                            begin
                                mem_wr_en         = 1'b1;
                                mem_wr_data.tare  = raw_reg;
                                mem_wr_data.shown = '0;
                            end
                            lcwc_pkg::KIND_ZERO:
                            begin
                                mem_wr_en         = 1'b1;
                                mem_wr_data.tare  = raw_reg;
                                mem_wr_data.zref  = raw_reg;
                                mem_wr_data.shown = '0;
                            end
                            default:
                            begin
                                if (small_reg)
                                begin
                                    out_status_next = lcwc_pkg::STAT_SPAN_LOW;
                                    out_shown_next  = rec_reg.shown;
                                end
                                else
                                begin
                                    out_weight_next   = W_W'(mass_cg_reg);
                                    out_shown_next    = W_W'(mass_cg_reg);
                                    mem_wr_en         = 1'b1;
                                    mem_wr_data.span  = diff_reg;
                                    mem_wr_data.shown = W_W'(mass_cg_reg);
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        ch_reg         <= ch_next;
        raw_reg        <= raw_next;
        present_reg    <= present_next;
        rec_reg        <= rec_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        small_reg      <= small_next;
        w_reg          <= w_next;
        out_ch_reg     <= out_ch_next;
        out_status_reg <= out_status_next;
        out_weight_reg <= out_weight_next;
        out_shown_reg  <= out_shown_next;
    end

    assign reading.ready      = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.out_channel = out_ch_reg;
    assign result.status      = out_status_reg;
    assign result.weight_cg   = out_weight_reg;
    assign result.shown_cg    = out_shown_reg;

endmodule
